// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the core RTL files.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define MEXP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MEXP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mexp_pkg.sv =====
// Widths and constants of the modular exponentiation core.
// No dependencies; used by the channel interfaces and the top level.
package mexp_pkg;

   localparam int BASE_BITS        = 30;
   localparam int RES_BITS         = 30;
   localparam int EXP_BITS_DEFAULT = 31;

   localparam logic [63:0] PRIME_WIDE = 64'd1000000007;
   localparam logic [RES_BITS-1:0] PRIME_MOD = PRIME_WIDE[RES_BITS-1:0];
   localparam logic [31:0] TWO_PRIME   = 32'd2000000014;
   localparam logic [31:0] THREE_PRIME = 32'd3000000021;

   // floor(2^60 / prime), the Barrett reciprocal
   localparam logic [63:0] MU_WIDE = (64'd1 << 60) / PRIME_WIDE;
   localparam logic [30:0] BARRETT_MU = MU_WIDE[30:0];

   localparam logic [RES_BITS-1:0] RES_ONE = 30'd1;

endpackage

// ===== rtl/core/mexp_if.sv =====
// Valid/ready channel interfaces for request and response transfers.
// Depends on mexp_pkg.
interface mexp_req_if #(
   parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEFAULT
);
   logic                           valid;
   logic                           ready;
   logic [mexp_pkg::BASE_BITS-1:0] base;
   logic [EXP_BITS-1:0]            exponent;

   modport source (output valid, output base, output exponent, input ready);
   modport sink (input valid, input base, input exponent, output ready);
endinterface

interface mexp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mexp_pkg::RES_BITS-1:0] power_mod;

   modport source (output valid, output power_mod, input ready);
   modport sink (input valid, input power_mod, output ready);
endinterface

// ===== rtl/core/modular_exponentiation.sv =====
// Modular exponentiation core: base^exponent mod 1000000007.
// Depends on mexp_pkg, mexp_if.sv and assert_macros.svh.
// Usage:
//   req_chan (sink) transfers one base/exponent pair when valid and ready
//   are both high; ready is high only while the core is idle.
//   rsp_chan (source) presents power_mod with valid until ready takes it.
// Operation:
//   Right-to-left square-and-multiply over the exponent bits. All
//   multiplications run through one 32x32 multiplier; each modular product
//   passes through the steps product, Barrett quotient, quotient times prime,
//   subtract and final correction.
// Request acceptance:
//   A zero exponent goes from the round state to the finish state. The core
//   takes no new request until the previous result has been written to the
//   output register; that result may still wait there for ready.
// Stall:
//   A result that is not taken holds in the output register; a later
//   result waits in the finish state until that register frees up.
// Reset:
//   Synchronous, active high; the core goes idle and drops response valid.
`include "assert_macros.svh"

module modular_exponentiation #(
   parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   mexp_req_if.sink  req_chan,
   mexp_rsp_if.source rsp_chan
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_ROUND  = 8'b0000_0010,
      ST_MUL    = 8'b0000_0100,
      ST_BAR    = 8'b0000_1000,
      ST_QP     = 8'b0001_0000,
      ST_SUB    = 8'b0010_0000,
      ST_CORR   = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [mexp_pkg::RES_BITS-1:0] acc_ff, acc_in;
   logic [mexp_pkg::RES_BITS-1:0] sq_ff, sq_in;
   logic [EXP_BITS-1:0]           e_ff, e_in;
   logic                          tgt_acc_ff, tgt_acc_in;
   logic [59:0]                   x_ff, x_in;
   logic [61:0]                   prod_ff, prod_in;
   logic [31:0]                   r_ff, r_in;
   logic [mexp_pkg::RES_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic [31:0]                   mul_a, mul_b;
   logic [63:0]                   mul_p;
   logic [mexp_pkg::RES_BITS-1:0] base_red;
   logic [mexp_pkg::RES_BITS-1:0] r_red;
   logic                          out_free;

   assign mul_p = 64'(mul_a) * 64'(mul_b);

   assign base_red = (req_chan.base >= mexp_pkg::PRIME_MOD) ?
                     req_chan.base - mexp_pkg::PRIME_MOD : req_chan.base;

   always_comb begin
      if (r_ff >= mexp_pkg::TWO_PRIME) begin
         r_red = 30'(r_ff - mexp_pkg::TWO_PRIME);
      end else if (r_ff >= {2'b00, mexp_pkg::PRIME_MOD}) begin
         r_red = 30'(r_ff - {2'b00, mexp_pkg::PRIME_MOD});
      end else begin
         r_red = r_ff[29:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      case (state_ff)
         ST_MUL: begin
            mul_a = {2'b00, (tgt_acc_ff ? acc_ff : sq_ff)};
            mul_b = {2'b00, sq_ff};
         end
         ST_BAR: begin
            mul_a = {1'b0, x_ff[59:29]};
            mul_b = {1'b0, mexp_pkg::BARRETT_MU};
         end
         ST_QP: begin
            mul_a = {2'b00, prod_ff[60:31]};
            mul_b = {2'b00, mexp_pkg::PRIME_MOD};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      e_in         = e_ff;
      tgt_acc_in   = tgt_acc_ff;
      x_in         = x_ff;
      prod_in      = prod_ff;
      r_in         = r_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               acc_in   = mexp_pkg::RES_ONE;
               sq_in    = base_red;
               e_in     = req_chan.exponent;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            tgt_acc_in = e_ff[0];
            state_in   = (e_ff == '0) ? ST_FINISH : ST_MUL;
         end
         ST_MUL: begin
            x_in     = mul_p[59:0];
            state_in = ST_BAR;
         end
         ST_BAR: begin
            prod_in  = mul_p[61:0];
            state_in = ST_QP;
         end
         ST_QP: begin
            prod_in  = mul_p[61:0];
            state_in = ST_SUB;
         end
         ST_SUB: begin
            r_in     = x_ff[31:0] - prod_ff[31:0];
            state_in = ST_CORR;
         end
         ST_CORR: begin
            if (tgt_acc_ff) begin
               acc_in     = r_red;
               tgt_acc_in = 1'b0;
               state_in   = ST_MUL;
            end else begin
               sq_in    = r_red;
               e_in     = e_ff >> 1;
               state_in = ST_ROUND;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_data_in  = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      e_ff        <= e_in;
      tgt_acc_ff  <= tgt_acc_in;
      x_ff        <= x_in;
      prod_ff     <= prod_in;
      r_ff        <= r_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.power_mod = rsp_data_ff;

   `MEXP_ASSERT(a_barrett_bound, clock, reset, (state_ff == ST_CORR) |-> (r_ff < mexp_pkg::THREE_PRIME), "Barrett remainder out of range")
   `MEXP_ASSERT(a_operands_reduced, clock, reset, (state_ff == ST_ROUND) |-> (acc_ff < mexp_pkg::PRIME_MOD && sq_ff < mexp_pkg::PRIME_MOD), "operand not reduced")
   `MEXP_ASSERT(a_exp_shift, clock, reset, (state_ff == ST_CORR && !tgt_acc_ff) |=> (e_ff == ($past(e_ff) >> 1)), "exponent not advanced")
   `MEXP_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff), "reset did not idle the core")

endmodule
